@@ src/a5d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5d_pkg
// Shared types, constants and pattern tables for the A5 world decompressor.
// ----------------------------------------------------------------------------
package a5d_pkg;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int COUNT_W   = 7;
    localparam int IDX_W     = COUNT_W - 1;

    localparam logic [1:0] KIND_FILL    = 2'd0;
    localparam logic [1:0] KIND_PATTERN = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic REG_BASE_ADDRESS     = 1'b0;
    localparam logic REG_JUMP_TABLE_START = 1'b1;

    localparam logic [31:0] JUMP_TABLE_START_RESET = 32'd40;

    localparam logic [63:0] PAT_ROW0 = 64'h0000_FFFF_0000_0000;
    localparam logic [63:0] PAT_ROW1 = 64'h0000_00FF_0000_0000;
    localparam logic [63:0] PAT_ROW2 = 64'h0000_0000_0000_F0A9;
    localparam logic [63:0] PAT_ROW3 = 64'h0000_0000_0000_F0A9;

    localparam logic [7:0] PAT_SRC0 = 8'hC0;
    localparam logic [7:0] PAT_SRC1 = 8'hE0;
    localparam logic [7:0] PAT_SRC2 = 8'hB0;
    localparam logic [7:0] PAT_SRC3 = 8'hB8;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        addr;
        logic [COUNT_W-1:0] count;
        logic [7:0]         data;
        logic [1:0]         sel;
        logic [2:0]         pos;
        logic               seg_end;
        logic               done;
        logic               jump;
        logic               bad;
    } cmd_t;

    function automatic logic [7:0] pat_src(input logic [1:0] sel);
        logic [7:0] m;
        begin
            case (sel)
                2'd0:    m = PAT_SRC0;
                2'd1:    m = PAT_SRC1;
                2'd2:    m = PAT_SRC2;
                2'd3:    m = PAT_SRC3;
                default: m = PAT_SRC0;
            endcase
            return m;
        end
    endfunction

    function automatic logic [7:0] pat_byte(input logic [1:0] sel, input logic [2:0] pos);
        logic [63:0] row;
        begin
            case (sel)
                2'd0:    row = PAT_ROW0;
                2'd1:    row = PAT_ROW1;
                2'd2:    row = PAT_ROW2;
                2'd3:    row = PAT_ROW3;
                default: row = PAT_ROW0;
            endcase
            return row[{pos, 3'b000} +: 8];
        end
    endfunction

    // Count fixed bytes from pos up to the next source slot or the pattern end.
    function automatic logic [3:0] fixed_len(input logic [1:0] sel, input logic [3:0] pos);
        logic [3:0] cnt;
        logic       stop;
        logic [7:0] src;
        begin
            cnt  = 4'd0;
            stop = 1'b0;
            src  = pat_src(sel);
            for (int p = 0; p < 8; p++)
            begin
                if ((4'(p) >= pos) && !stop)
                begin
                    if (src[p])
                        stop = 1'b1;
                    else
                        cnt = cnt + 4'd1;
                end
            end
            return cnt;
        end
    endfunction

endpackage

@@ src/a5_data_stream_decompressor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5_data_stream_decompressor
// Rebuilds an A5 globals area from a compressed byte stream as write events.
// ----------------------------------------------------------------------------
// The parser takes one stream byte per cycle while its four-entry command
// queue has room; each byte turns into at most one command. The emitter
// drains the queue at one result per cycle while out_ready allows, so a
// byte that expands into N results (fills of up to 64, pattern runs of up
// to 6) holds the output for all N results; input stalls once the queue is
// full. Literal bytes and status events pass at one per cycle. An accepted
// byte's command goes through the queue, then the registered output stage.
// Configuration writes take effect at the next completed segment offset.
// ----------------------------------------------------------------------------
module a5_data_stream_decompressor #(
    parameter int SEGMENT_COUNT = 3,
    parameter int HEADER_BYTES  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        start_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_write,
    output logic [31:0] out_address,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        segment_end,
    output logic        stream_done,
    output logic        into_jump_table,
    output logic        bad_code
);

    logic          cmd_push;
    a5d_pkg::cmd_t cmd_wdata;
    logic          cmd_full;
    logic          cmd_pop;
    a5d_pkg::cmd_t cmd_rdata;
    logic          cmd_nonempty;

    a5d_front #(
        .SEGMENT_COUNT (SEGMENT_COUNT),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .start_stream (start_stream),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_wdata),
        .cmd_full     (cmd_full)
    );

    a5d_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .wdata    (cmd_wdata),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .rdata    (cmd_rdata),
        .nonempty (cmd_nonempty)
    );

    a5d_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_nonempty),
        .cmd             (cmd_rdata),
        .cmd_pop         (cmd_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .is_write        (is_write),
        .out_address     (out_address),
        .out_byte        (out_byte),
        .run_last        (run_last),
        .segment_end     (segment_end),
        .stream_done     (stream_done),
        .into_jump_table (into_jump_table),
        .bad_code        (bad_code)
    );

endmodule

@@ src/a5d_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5d_front
// Stream parser: skips the header, gathers segment offsets, decodes codes and
// issues one write-run or status command per input byte that yields results.
// ----------------------------------------------------------------------------
module a5d_front #(
    parameter int SEGMENT_COUNT = 3,
    parameter int HEADER_BYTES  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              start_stream,
    output logic              cmd_push,
    output a5d_pkg::cmd_t     cmd_data,
    input  logic              cmd_full
);

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_OFFSET   = 3'd1;
    localparam logic [2:0] PH_CODE     = 3'd2;
    localparam logic [2:0] PH_LITERAL  = 3'd3;
    localparam logic [2:0] PH_FILLDATA = 3'd4;
    localparam logic [2:0] PH_PATTERN  = 3'd5;
    localparam logic [2:0] PH_DONE     = 3'd6;

    localparam logic [2:0] PH_START = (HEADER_BYTES == 0) ? PH_OFFSET : PH_HEADER;

    logic [2:0]  phase_reg,  phase_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] dest_reg,   dest_next;
    logic [1:0]  seg_reg,    seg_next;
    logic [7:0]  run_reg,    run_next;
    logic [1:0]  sel_reg,    sel_next;
    logic        jump_reg,   jump_next;
    logic        err_reg,    err_next;
    logic [31:0] base_reg;
    logic [31:0] jts_reg;

    assign in_ready = !cmd_full;

    always_comb
    begin
        logic [2:0]  ph;
        logic [2:0]  cnt;
        logic [31:0] gat;
        logic [31:0] dst;
        logic [1:0]  seg;
        logic [7:0]  run;
        logic [1:0]  sel;
        logic        jmp;
        logic        err;
        logic [3:0]  flen;
        logic [3:0]  npos;
        logic [3:0]  cnt_inc;
        logic        last;

        ph   = phase_reg;
        cnt  = cnt_reg;
        gat  = gather_reg;
        dst  = dest_reg;
        seg  = seg_reg;
        run  = run_reg;
        sel  = sel_reg;
        jmp  = jump_reg;
        err  = err_reg;
        flen = 4'd0;
        npos = 4'd0;
        cnt_inc = 4'd0;
        last = 1'b0;
        cmd_push = 1'b0;
        cmd_data = '0;
        cmd_data.kind = a5d_pkg::KIND_FILL;

        if (in_valid && in_ready)
        begin
            if (start_stream)
            begin
                ph  = PH_START;
                cnt = 3'd0;
                gat = 32'd0;
                dst = 32'd0;
                seg = 2'd0;
                run = 8'd0;
                sel = 2'd0;
                jmp = 1'b0;
                err = 1'b0;
            end
            cnt_inc = {1'b0, cnt} + 4'd1;
            cmd_data.addr = dst;
            cmd_data.data = in_byte;
            if (!err && ph != PH_DONE)
            begin
                case (ph)
                    PH_HEADER:
                    begin
                        cnt = cnt_inc[2:0];
                        if (cnt_inc >= 4'(HEADER_BYTES))
                        begin
                            cnt = 3'd0;
                            gat = 32'd0;
                            ph  = PH_OFFSET;
                        end
                    end
                    PH_OFFSET:
                    begin
                        gat = {gat[23:0], in_byte};
                        cnt = cnt_inc[2:0];
                        if (cnt_inc >= 4'd4)
                        begin
                            cnt = 3'd0;
                            jmp = ($signed(gat) >= $signed(jts_reg));
                            dst = base_reg + gat;
                            cmd_push      = 1'b1;
                            cmd_data.kind = a5d_pkg::KIND_STATUS;
                            cmd_data.addr = dst;
                            cmd_data.data = 8'd0;
                            cmd_data.count = a5d_pkg::COUNT_W'(1);
                            ph = PH_CODE;
                        end
                    end
                    PH_CODE:
                    begin
                        if (in_byte[7])
                        begin
                            run = {1'b0, in_byte[6:0]} + 8'd1;
                            ph  = PH_LITERAL;
                        end
                        else if (in_byte[6])
                        begin
                            cmd_push       = 1'b1;
                            cmd_data.data  = 8'h00;
                            cmd_data.count = {1'b0, in_byte[5:0]} + 7'd1;
                            dst = dst + 32'(cmd_data.count);
                        end
                        else if (in_byte[5])
                        begin
                            run = {3'b000, in_byte[4:0]} + 8'd2;
                            ph  = PH_FILLDATA;
                        end
                        else if (in_byte[4])
                        begin
                            cmd_push       = 1'b1;
                            cmd_data.data  = 8'hFF;
                            cmd_data.count = {3'b000, in_byte[3:0]} + 7'd1;
                            dst = dst + 32'(cmd_data.count);
                        end
                        else if (in_byte == 8'd0)
                        begin
                            last = (({1'b0, seg} + 3'd1) >= 3'(SEGMENT_COUNT));
                            cmd_push         = 1'b1;
                            cmd_data.kind    = a5d_pkg::KIND_STATUS;
                            cmd_data.data    = 8'd0;
                            cmd_data.count   = a5d_pkg::COUNT_W'(1);
                            cmd_data.seg_end = 1'b1;
                            cmd_data.done    = last;
                            if (last)
                                ph = PH_DONE;
                            else
                            begin
                                seg = seg + 2'd1;
                                ph  = PH_OFFSET;
                                cnt = 3'd0;
                                gat = 32'd0;
                            end
                        end
                        else if (in_byte <= 8'd4)
                        begin
                            sel  = 2'(in_byte - 8'd1);
                            flen = a5d_pkg::fixed_len(sel, 4'd0);
                            npos = flen;
                            cmd_push       = (flen != 4'd0);
                            cmd_data.kind  = a5d_pkg::KIND_PATTERN;
                            cmd_data.sel   = sel;
                            cmd_data.pos   = 3'd0;
                            cmd_data.count = {3'b000, flen};
                            dst = dst + 32'(flen);
                            if (npos[3])
                            begin
                                cnt = 3'd0;
                                ph  = PH_CODE;
                            end
                            else
                            begin
                                cnt = npos[2:0];
                                ph  = PH_PATTERN;
                            end
                        end
                        else
                        begin
                            err = 1'b1;
                            cmd_push       = 1'b1;
                            cmd_data.kind  = a5d_pkg::KIND_STATUS;
                            cmd_data.data  = 8'd0;
                            cmd_data.count = a5d_pkg::COUNT_W'(1);
                            cmd_data.bad   = 1'b1;
                        end
                    end
                    PH_LITERAL:
                    begin
                        cmd_push       = 1'b1;
                        cmd_data.count = a5d_pkg::COUNT_W'(1);
                        dst = dst + 32'd1;
                        if (run != 8'd0)
                            run = run - 8'd1;
                        if (run == 8'd0)
                            ph = PH_CODE;
                    end
                    PH_FILLDATA:
                    begin
                        cmd_push       = (run != 8'd0);
                        cmd_data.count = run[a5d_pkg::COUNT_W-1:0];
                        dst = dst + {24'd0, run};
                        run = 8'd0;
                        ph  = PH_CODE;
                    end
                    PH_PATTERN:
                    begin
                        flen = a5d_pkg::fixed_len(sel, cnt_inc);
                        npos = cnt_inc + flen;
                        cmd_push       = 1'b1;
                        cmd_data.kind  = a5d_pkg::KIND_PATTERN;
                        cmd_data.sel   = sel;
                        cmd_data.pos   = cnt;
                        cmd_data.count = {3'b000, flen} + 7'd1;
                        dst = dst + 32'(cmd_data.count);
                        if (npos[3])
                        begin
                            cnt = 3'd0;
                            ph  = PH_CODE;
                        end
                        else
                            cnt = npos[2:0];
                    end
                    default:
                    begin
                        ph = phase_reg;
                    end
                endcase
            end
            cmd_data.jump = jmp;
        end

        phase_next  = ph;
        cnt_next    = cnt;
        gather_next = gat;
        dest_next   = dst;
        seg_next    = seg;
        run_next    = run;
        sel_next    = sel;
        jump_next   = jmp;
        err_next    = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            cnt_reg    <= 3'd0;
            gather_reg <= 32'd0;
            dest_reg   <= 32'd0;
            seg_reg    <= 2'd0;
            run_reg    <= 8'd0;
            sel_reg    <= 2'd0;
            jump_reg   <= 1'b0;
            err_reg    <= 1'b0;
            base_reg   <= 32'd0;
            jts_reg    <= a5d_pkg::JUMP_TABLE_START_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            gather_reg <= gather_next;
            dest_reg   <= dest_next;
            seg_reg    <= seg_next;
            run_reg    <= run_next;
            sel_reg    <= sel_next;
            jump_reg   <= jump_next;
            err_reg    <= err_next;
            if (cfg_write && cfg_index == a5d_pkg::REG_BASE_ADDRESS)
                base_reg <= cfg_data;
            if (cfg_write && cfg_index == a5d_pkg::REG_JUMP_TABLE_START)
                jts_reg <= cfg_data;
        end
    end

endmodule

@@ src/a5d_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5d_cmd_fifo
// Short command queue between the stream parser and the result emitter.
// ----------------------------------------------------------------------------
module a5d_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  a5d_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output a5d_pkg::cmd_t rdata,
    output logic          nonempty
);

    a5d_pkg::cmd_t                mem [a5d_pkg::CMD_DEPTH];
    logic [a5d_pkg::CMD_PTR_W-1:0] wptr_reg, wptr_next;
    logic [a5d_pkg::CMD_PTR_W-1:0] rptr_reg, rptr_next;
    logic [a5d_pkg::CMD_PTR_W:0]   fill_reg, fill_next;

    assign full     = (fill_reg == (a5d_pkg::CMD_PTR_W + 1)'(a5d_pkg::CMD_DEPTH));
    assign nonempty = (fill_reg != '0);
    assign rdata    = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push)
            wptr_next = wptr_reg + 1'b1;
        if (pop)
            rptr_next = rptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (!push && pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

@@ src/a5d_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a5d_back
// Result emitter: expands the head command into a registered output stage at
// one result per cycle while that stage is empty or being drained.
// ----------------------------------------------------------------------------
module a5d_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  a5d_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          is_write,
    output logic [31:0]   out_address,
    output logic [7:0]    out_byte,
    output logic          run_last,
    output logic          segment_end,
    output logic          stream_done,
    output logic          into_jump_table,
    output logic          bad_code
);

    logic [a5d_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    logic                      load;
    logic                      last;
    logic [2:0]                pos;
    logic [7:0]                pat_src_mask;
    logic [7:0]                byte_sel;

    logic        is_write_reg;
    logic [31:0] addr_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        seg_end_reg;
    logic        done_reg;
    logic        jump_reg;
    logic        bad_reg;

    assign load = cmd_valid && (!valid_reg || out_ready);
    assign last = (({1'b0, idx_reg} + a5d_pkg::COUNT_W'(1)) == cmd.count);
    assign cmd_pop = load && last;
    assign pos = cmd.pos + idx_reg[2:0];
    assign pat_src_mask = a5d_pkg::pat_src(cmd.sel);

    always_comb
    begin
        case (cmd.kind)
            a5d_pkg::KIND_PATTERN:
                byte_sel = pat_src_mask[pos] ? cmd.data : a5d_pkg::pat_byte(cmd.sel, pos);
            a5d_pkg::KIND_STATUS:
                byte_sel = 8'd0;
            default:
                byte_sel = cmd.data;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = last ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            is_write_reg <= (cmd.kind != a5d_pkg::KIND_STATUS);
            addr_reg     <= cmd.addr + 32'(idx_reg);
            byte_reg     <= byte_sel;
            last_reg     <= last;
            seg_end_reg  <= cmd.seg_end;
            done_reg     <= cmd.done;
            jump_reg     <= cmd.jump;
            bad_reg      <= cmd.bad;
        end
    end

    assign out_valid       = valid_reg;
    assign is_write        = is_write_reg;
    assign out_address     = addr_reg;
    assign out_byte        = byte_reg;
    assign run_last        = last_reg;
    assign segment_end     = seg_end_reg;
    assign stream_done     = done_reg;
    assign into_jump_table = jump_reg;
    assign bad_code        = bad_reg;

endmodule
